>>> rtl/core/mpid_pkg.sv
`timescale 1ns / 1ps

package mpid_pkg;

    // Controller constants: integration period (0.05 in Q16.16), derivative
    // scale for the raw law, and the derivative filter weight (0.2 in Q16.16).
    localparam int unsigned CYCLE_Q16        = 3277;
    localparam int unsigned INV_CYCLE        = 20;
    localparam int unsigned FILTER_ALPHA_Q16 = 13107;

    // A Q16.16 gain equal to INV_CYCLE turns the shared gain multiply into a
    // plain integer scale.
    localparam logic [31:0] INV_CYCLE_GAIN = 32'(INV_CYCLE * 65536);

    // Wrap bounds in Q24.8.
    localparam logic signed [33:0] HALF360  = 34'sd46080;
    localparam logic signed [33:0] FULL360  = 34'sd92160;
    localparam logic signed [33:0] HALF3600 = 34'sd460800;
    localparam logic signed [33:0] FULL3600 = 34'sd921600;

    localparam logic [1:0] LAW_POS  = 2'd0;
    localparam logic [1:0] LAW_RAW  = 2'd1;
    localparam logic [1:0] LAW_INCR = 2'd2;
    localparam logic [1:0] LAW_HOLD = 2'd3;

    localparam logic [1:0] SHAPE_NONE   = 2'd0;
    localparam logic [1:0] SHAPE_CLAMP  = 2'd1;
    localparam logic [1:0] SHAPE_OFFSET = 2'd2;

    localparam logic [1:0] WRAP_NONE = 2'd0;
    localparam logic [1:0] WRAP_360  = 2'd1;
    localparam logic [1:0] WRAP_3600 = 2'd2;

    localparam logic [2:0] REG_GAIN_P         = 3'd0;
    localparam logic [2:0] REG_GAIN_I         = 3'd1;
    localparam logic [2:0] REG_GAIN_D         = 3'd2;
    localparam logic [2:0] REG_INTEGRAL_LIMIT = 3'd3;
    localparam logic [2:0] REG_OUTPUT_LIMIT   = 3'd4;
    localparam logic [2:0] REG_DEAD_ZONE      = 3'd5;
    localparam logic [2:0] REG_DRIVE_OFFSET   = 3'd6;
    localparam logic [2:0] REG_MODE_WORD      = 3'd7;

    typedef struct packed {
        logic [31:0]        gain_p;
        logic [31:0]        gain_i;
        logic [31:0]        gain_d;
        logic [30:0]        integral_limit;
        logic [30:0]        output_limit;
        logic [30:0]        dead_zone;
        logic signed [31:0] drive_offset;
        logic [1:0]         law;
        logic [1:0]         shape;
        logic [1:0]         wrap;
        logic               enable;
    } cfg_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_WRAP,
        S_SUM,
        S_MUL,
        S_WAIT,
        S_FINAL,
        S_OFS,
        S_SHAPE,
        S_DONE
    } seq_state_t;

    function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
        logic signed [31:0] r;
        if (v > 40'sd2147483647)
        begin
            r = 32'sh7FFFFFFF;
        end
        else if (v < -40'sd2147483648)
        begin
            r = 32'sh80000000;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [47:0] sat48(input logic signed [48:0] v);
        logic signed [47:0] r;
        if (v > 49'sh07FFFFFFFFFFF)
        begin
            r = 48'sh7FFFFFFFFFFF;
        end
        else if (v < -49'sh0800000000000)
        begin
            r = 48'sh800000000000;
        end
        else
        begin
            r = v[47:0];
        end
        return r;
    endfunction

endpackage

>>> rtl/core/mpid_if.sv
`timescale 1ns / 1ps

interface mpid_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] setpoint;
    logic signed [31:0] measured;

    modport source (output valid, output setpoint, output measured, input ready);
    modport sink   (input valid, input setpoint, input measured, output ready);
endinterface

interface mpid_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] drive;
    logic               clamped;
    logic               active;

    modport source (output valid, output drive, output clamped, output active, input ready);
    modport sink   (input valid, input drive, input clamped, input active, output ready);
endinterface

>>> rtl/core/mpid_cfg.sv
`timescale 1ns / 1ps

module mpid_cfg
    import mpid_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_wdata,
    output cfg_t        cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain_p         <= 32'd4915200;
            cfg_reg.gain_i         <= 32'd49152;
            cfg_reg.gain_d         <= 32'd5242880;
            cfg_reg.integral_limit <= 31'd3413333;
            cfg_reg.output_limit   <= 31'd128000;
            cfg_reg.dead_zone      <= 31'd512;
            cfg_reg.drive_offset   <= '0;
            cfg_reg.law            <= LAW_POS;
            cfg_reg.shape          <= SHAPE_NONE;
            cfg_reg.wrap           <= WRAP_NONE;
            cfg_reg.enable         <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_GAIN_P:         cfg_reg.gain_p         <= cfg_wdata;
                REG_GAIN_I:         cfg_reg.gain_i         <= cfg_wdata;
                REG_GAIN_D:         cfg_reg.gain_d         <= cfg_wdata;
                REG_INTEGRAL_LIMIT: cfg_reg.integral_limit <= cfg_wdata[30:0];
                REG_OUTPUT_LIMIT:   cfg_reg.output_limit   <= cfg_wdata[30:0];
                REG_DEAD_ZONE:      cfg_reg.dead_zone      <= cfg_wdata[30:0];
                REG_DRIVE_OFFSET:   cfg_reg.drive_offset   <= cfg_wdata;
                REG_MODE_WORD:
                begin
                    cfg_reg.law    <= cfg_wdata[1:0];
                    cfg_reg.shape  <= cfg_wdata[3:2];
                    cfg_reg.wrap   <= cfg_wdata[5:4];
                    cfg_reg.enable <= cfg_wdata[6];
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> rtl/core/mpid_mul.sv
`timescale 1ns / 1ps

// Sign-magnitude gain multiply: result = sign(v) * floor(|v| * gain / 65536),
// optionally rounded, saturated to 34 bits. One 32x16 partial product per
// cycle, most significant chunk first.
module mpid_mul
    import mpid_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [47:0] operand,
    input  logic [31:0]        gain,
    input  logic               rnd,
    output logic               done,
    output logic signed [33:0] result
);

    logic [47:0]        mag_reg;
    logic               neg_reg;
    logic [31:0]        g_reg;
    logic               rnd_reg;
    logic [79:0]        acc_reg;
    logic [1:0]         cnt_reg;
    logic               run_reg;
    logic               fin_reg;
    logic               done_reg;
    logic signed [33:0] result_reg;

    logic [15:0]        chunk;
    logic [47:0]        prod;
    logic [63:0]        quo;
    logic [32:0]        mag_sat;

    always_comb
    begin
        unique case (cnt_reg)
            2'd0:    chunk = mag_reg[47:32];
            2'd1:    chunk = mag_reg[31:16];
            2'd2:    chunk = mag_reg[15:0];
            default: chunk = '0;
        endcase
    end

    assign prod    = g_reg * chunk;
    assign quo     = acc_reg[79:16] + 64'(rnd_reg & acc_reg[15]);
    assign mag_sat = (quo[63:33] != '0) ? {33{1'b1}} : quo[32:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 2'd1;
                if (cnt_reg == 2'd2)
                begin
                    run_reg <= 1'b0;
                    fin_reg <= 1'b1;
                end
            end
            else if (fin_reg)
            begin
                fin_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= operand[47];
            mag_reg <= operand[47] ? 48'(-operand) : operand;
            g_reg   <= gain;
            rnd_reg <= rnd;
            acc_reg <= '0;
        end
        else if (run_reg)
        begin
            acc_reg <= {acc_reg[63:0], 16'd0} + 80'(prod);
        end
        else if (fin_reg)
        begin
            result_reg <= neg_reg ? -$signed({1'b0, mag_sat}) : $signed({1'b0, mag_sat});
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

>>> rtl/core/multimode_pid_controller_core.sv
`timescale 1ns / 1ps

// Channel   Port                 Direction  Beat content
// tick      mpid_in_if.sink      in         setpoint, measured (Q24.8)
// ctl       mpid_out_if.source   out        drive (Q24.8), clamped, active
// cfg       cfg_wr_en/index/data in         one register write per enabled cycle
//
// One tick is worked at a time; tick.ready is high only while idle.
// The shared gain multiplier serves five products per enabled positional or
// raw tick and three per incremental tick; hold law and disabled ticks skip it.
// The result sits in an output register, so a new tick is taken while ctl stalls.
// Reset clears the controller history and loads the register defaults.
module multimode_pid_controller_core
    import mpid_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    mpid_in_if.sink     tick,
    mpid_out_if.source  ctl,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_wdata
);

    cfg_t cfg;

    seq_state_t state_reg;
    seq_state_t state_next;

    // Controller history.
    logic signed [47:0] sum_reg;
    logic signed [31:0] prev_reg;
    logic signed [31:0] prev2_reg;
    logic signed [31:0] df_reg;
    logic signed [31:0] last_reg;

    // Working registers.
    logic signed [32:0] diff_reg;
    logic signed [31:0] e_reg;
    logic signed [34:0] acc_reg;
    logic signed [31:0] tmp_reg;
    logic [31:0]        kc_reg;
    logic signed [31:0] u_reg;
    logic [2:0]         step_reg;
    logic signed [31:0] res_drive_reg;
    logic               res_clamped_reg;
    logic               res_active_reg;

    logic               out_valid_reg;
    logic signed [31:0] out_drive_reg;
    logic               out_clamped_reg;
    logic               out_active_reg;

    logic               in_acc;
    logic               out_load;
    logic               mul_start;
    logic               mul_done;
    logic signed [33:0] mul_res;
    logic signed [47:0] op_v;
    logic [31:0]        op_g;
    logic               op_rnd;
    logic [2:0]         last_step;

    logic signed [32:0] d_ep;
    logic signed [33:0] d_2nd;
    logic signed [32:0] d_df;
    logic signed [33:0] d34;
    logic signed [33:0] wrapped;
    logic signed [33:0] ilim_s;
    logic signed [33:0] res_ilim;
    logic signed [31:0] res_sat;
    logic signed [31:0] df_new;
    logic signed [31:0] olim_s;
    logic signed [31:0] dz_s;
    logic signed [31:0] shaped;
    logic               cut;

    mpid_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    mpid_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .operand (op_v),
        .gain    (op_g),
        .rnd     (op_rnd),
        .done    (mul_done),
        .result  (mul_res)
    );

    assign in_acc = tick.valid && tick.ready;

    // Error and derivative-filter differences fed to the multiplier.
    assign d_ep  = 33'(e_reg) - 33'(prev_reg);
    assign d_2nd = 34'(e_reg) - (34'(prev_reg) <<< 1) + 34'(prev2_reg);
    assign d_df  = 33'(tmp_reg) - 33'(df_reg);
    assign last_step = (cfg.law == LAW_INCR) ? 3'd2 : 3'd4;

    always_comb
    begin
        op_v   = '0;
        op_g   = '0;
        op_rnd = 1'b0;
        unique case (cfg.law)
            LAW_POS:
            begin
                unique case (step_reg)
                    3'd0:    begin op_v = 48'(CYCLE_Q16); op_g = cfg.gain_i; op_rnd = 1'b1; end
                    3'd1:    begin op_v = sum_reg;       op_g = kc_reg; end
                    3'd2:    begin op_v = 48'(d_ep);     op_g = cfg.gain_d; end
                    3'd3:    begin op_v = 48'(d_df);     op_g = 32'(FILTER_ALPHA_Q16); end
                    3'd4:    begin op_v = 48'(e_reg);    op_g = cfg.gain_p; end
                    default: begin op_v = '0;            op_g = '0; end
                endcase
            end
            LAW_RAW:
            begin
                unique case (step_reg)
                    3'd0:    begin op_v = 48'(CYCLE_Q16); op_g = cfg.gain_i; op_rnd = 1'b1; end
                    3'd1:    begin op_v = sum_reg;       op_g = kc_reg; end
                    3'd2:    begin op_v = 48'(e_reg);    op_g = cfg.gain_p; end
                    3'd3:    begin op_v = 48'(d_ep);     op_g = cfg.gain_d; end
                    3'd4:    begin op_v = 48'(tmp_reg);  op_g = INV_CYCLE_GAIN; end
                    default: begin op_v = '0;            op_g = '0; end
                endcase
            end
            LAW_INCR:
            begin
                unique case (step_reg)
                    3'd0:    begin op_v = 48'(d_ep);  op_g = cfg.gain_p; end
                    3'd1:    begin op_v = 48'(e_reg); op_g = cfg.gain_i; end
                    3'd2:    begin op_v = 48'(d_2nd); op_g = cfg.gain_d; end
                    default: begin op_v = '0;         op_g = '0; end
                endcase
            end
            default:
            begin
                op_v = '0;
            end
        endcase
    end

    // Wrap once by a full circle, then saturate.
    assign d34 = 34'(diff_reg);
    always_comb
    begin
        wrapped = d34;
        priority if (cfg.wrap == WRAP_360 && d34 > HALF360)
        begin
            wrapped = d34 - FULL360;
        end
        else if (cfg.wrap == WRAP_360 && d34 < -HALF360)
        begin
            wrapped = d34 + FULL360;
        end
        else if (cfg.wrap == WRAP_3600 && d34 > HALF3600)
        begin
            wrapped = d34 - FULL3600;
        end
        else if (cfg.wrap == WRAP_3600 && d34 < -HALF3600)
        begin
            wrapped = d34 + FULL3600;
        end
        else
        begin
            wrapped = d34;
        end
    end

    assign ilim_s  = {3'b000, cfg.integral_limit};
    assign res_ilim = (mul_res > ilim_s) ? ilim_s : ((mul_res < -ilim_s) ? -ilim_s : mul_res);
    assign res_sat = sat32(40'(mul_res));
    assign df_new  = df_reg + mul_res[31:0];

    assign olim_s = {1'b0, cfg.output_limit};
    assign dz_s   = {1'b0, cfg.dead_zone};
    always_comb
    begin
        shaped = u_reg;
        cut    = 1'b0;
        if (cfg.shape == SHAPE_CLAMP || cfg.shape == SHAPE_OFFSET)
        begin
            priority if (u_reg > olim_s)
            begin
                shaped = olim_s;
                cut    = 1'b1;
            end
            else if (u_reg < dz_s && u_reg > -dz_s)
            begin
                shaped = '0;
            end
            else if (u_reg < -olim_s)
            begin
                shaped = -olim_s;
                cut    = 1'b1;
            end
            else
            begin
                shaped = u_reg;
            end
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = cfg.enable ? S_WRAP : S_DONE;
                end
            end
            S_WRAP:
            begin
                unique case (cfg.law)
                    LAW_POS, LAW_RAW: state_next = S_SUM;
                    LAW_INCR:         state_next = S_MUL;
                    default:          state_next = S_FINAL;
                endcase
            end
            S_SUM:   state_next = S_MUL;
            S_MUL:   state_next = S_WAIT;
            S_WAIT:
            begin
                if (mul_done)
                begin
                    state_next = (step_reg == last_step) ? S_FINAL : S_MUL;
                end
            end
            S_FINAL: state_next = S_OFS;
            S_OFS:   state_next = S_SHAPE;
            S_SHAPE: state_next = S_DONE;
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // State outputs.
    always_comb
    begin
        tick.ready = (state_reg == S_IDLE);
        mul_start  = (state_reg == S_MUL);
        out_load   = (state_reg == S_DONE) && (!out_valid_reg || ctl.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            sum_reg       <= '0;
            prev_reg      <= '0;
            prev2_reg     <= '0;
            df_reg        <= '0;
            last_reg      <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (ctl.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (state_reg == S_SUM)
            begin
                sum_reg <= sat48(49'(sum_reg) + 49'(e_reg));
            end
            if (state_reg == S_WAIT && mul_done && cfg.law == LAW_POS && step_reg == 3'd3)
            begin
                df_reg <= df_new;
            end
            if (state_reg == S_FINAL && cfg.law != LAW_HOLD)
            begin
                prev2_reg <= prev_reg;
                prev_reg  <= e_reg;
            end
            if (state_reg == S_SHAPE)
            begin
                last_reg <= shaped;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                diff_reg        <= 33'(tick.setpoint) - 33'(tick.measured);
                res_drive_reg   <= last_reg;
                res_clamped_reg <= 1'b0;
                res_active_reg  <= 1'b0;
            end
            S_WRAP:
            begin
                e_reg    <= sat32(40'(wrapped));
                step_reg <= '0;
                unique case (cfg.law)
                    LAW_POS: acc_reg <= '0;
                    LAW_RAW: acc_reg <= 35'(cfg.drive_offset);
                    default: acc_reg <= 35'(last_reg);
                endcase
            end
            S_WAIT:
            begin
                if (mul_done)
                begin
                    step_reg <= step_reg + 3'd1;
                    if (cfg.law != LAW_INCR && step_reg == 3'd0)
                    begin
                        kc_reg <= mul_res[31:0];
                    end
                    else if (cfg.law == LAW_POS && step_reg == 3'd1)
                    begin
                        acc_reg <= acc_reg + 35'(res_ilim);
                    end
                    else if ((cfg.law == LAW_POS && step_reg == 3'd2)
                             || (cfg.law == LAW_RAW && step_reg == 3'd3))
                    begin
                        tmp_reg <= res_sat;
                    end
                    else if (cfg.law == LAW_POS && step_reg == 3'd3)
                    begin
                        acc_reg <= acc_reg + 35'(df_new);
                    end
                    else
                    begin
                        acc_reg <= acc_reg + 35'(res_sat);
                    end
                end
            end
            S_FINAL:
            begin
                u_reg <= sat32(40'(acc_reg));
            end
            S_OFS:
            begin
                if (cfg.shape == SHAPE_OFFSET)
                begin
                    u_reg <= sat32(40'(u_reg) + 40'(cfg.drive_offset));
                end
            end
            S_SHAPE:
            begin
                res_drive_reg   <= shaped;
                res_clamped_reg <= cut;
                res_active_reg  <= 1'b1;
            end
            default:
            begin
                if (out_load)
                begin
                    out_drive_reg   <= res_drive_reg;
                    out_clamped_reg <= res_clamped_reg;
                    out_active_reg  <= res_active_reg;
                end
            end
        endcase
    end

    assign ctl.valid   = out_valid_reg;
    assign ctl.drive   = out_drive_reg;
    assign ctl.clamped = out_clamped_reg;
    assign ctl.active  = out_active_reg;

endmodule

>>> rtl/core/mpid_chk.sv
`timescale 1ns / 1ps

module mpid_chk
    import mpid_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [31:0] drive,
    input logic               clamped,
    input logic               active
);

    // A stalled result beat holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(drive) && $stable(clamped))
        else $error("result beat changed while stalled");

    // The block works on one tick at a time.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("tick accepted while busy");

    // A clamp can only be reported by an active tick.
    a_clamp_active: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && clamped |-> active)
        else $error("clamp flagged on an inactive result");

    // No result appears in the cycle right after a tick is taken.
    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_valid && in_ready))
        else $error("result appeared too early");

endmodule

bind multimode_pid_controller_core mpid_chk u_mpid_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (tick.valid),
    .in_ready  (tick.ready),
    .out_valid (ctl.valid),
    .out_ready (ctl.ready),
    .drive     (ctl.drive),
    .clamped   (ctl.clamped),
    .active    (ctl.active)
);
